>>> rtl/core/hpack_pkg.sv
`timescale 1ns / 1ps

package hpack_pkg;

	localparam int MaxLen    = 30;
	localparam int SymCount  = 257;
	localparam logic [8:0] EOS_SYM = 9'd256;

	typedef logic [29:0] code_arr_t [0:MaxLen];
	typedef logic [8:0]  idx_arr_t  [0:MaxLen];
	typedef logic [8:0]  sym_arr_t  [0:SymCount-1];

	// Commands from the sequencer to the datapath
	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} hpack_cmd_t;

	// Status back to the sequencer
	typedef struct packed {
		logic halted;
	} hpack_stat_t;

	// Code length of every symbol, canonical code
	localparam logic [4:0] CODE_LEN [0:SymCount-1] = '{
		5'd13, 5'd23, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28,
		5'd28, 5'd24, 5'd30, 5'd28, 5'd28, 5'd30, 5'd28, 5'd28,
		5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd30, 5'd28,
		5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28,
		5'd6,  5'd10, 5'd10, 5'd12, 5'd13, 5'd6,  5'd8,  5'd11,
		5'd10, 5'd10, 5'd8,  5'd11, 5'd8,  5'd6,  5'd6,  5'd6,
		5'd5,  5'd5,  5'd5,  5'd6,  5'd6,  5'd6,  5'd6,  5'd6,
		5'd6,  5'd6,  5'd7,  5'd8,  5'd15, 5'd6,  5'd12, 5'd10,
		5'd13, 5'd6,  5'd7,  5'd7,  5'd7,  5'd7,  5'd7,  5'd7,
		5'd7,  5'd7,  5'd7,  5'd7,  5'd7,  5'd7,  5'd7,  5'd7,
		5'd7,  5'd7,  5'd7,  5'd7,  5'd7,  5'd7,  5'd7,  5'd7,
		5'd8,  5'd7,  5'd8,  5'd13, 5'd19, 5'd13, 5'd14, 5'd6,
		5'd15, 5'd5,  5'd6,  5'd5,  5'd6,  5'd5,  5'd6,  5'd6,
		5'd6,  5'd5,  5'd7,  5'd7,  5'd6,  5'd6,  5'd6,  5'd5,
		5'd6,  5'd7,  5'd6,  5'd5,  5'd5,  5'd6,  5'd7,  5'd7,
		5'd7,  5'd7,  5'd7,  5'd15, 5'd11, 5'd14, 5'd13, 5'd28,
		5'd20, 5'd22, 5'd20, 5'd20, 5'd22, 5'd22, 5'd22, 5'd23,
		5'd22, 5'd23, 5'd23, 5'd23, 5'd23, 5'd23, 5'd24, 5'd23,
		5'd24, 5'd24, 5'd22, 5'd23, 5'd24, 5'd23, 5'd23, 5'd23,
		5'd23, 5'd21, 5'd22, 5'd23, 5'd22, 5'd23, 5'd23, 5'd24,
		5'd22, 5'd21, 5'd20, 5'd22, 5'd22, 5'd23, 5'd23, 5'd21,
		5'd23, 5'd22, 5'd22, 5'd24, 5'd21, 5'd22, 5'd23, 5'd23,
		5'd21, 5'd21, 5'd22, 5'd21, 5'd23, 5'd22, 5'd23, 5'd23,
		5'd20, 5'd22, 5'd22, 5'd22, 5'd23, 5'd22, 5'd22, 5'd23,
		5'd26, 5'd26, 5'd20, 5'd19, 5'd22, 5'd23, 5'd22, 5'd25,
		5'd26, 5'd26, 5'd26, 5'd27, 5'd27, 5'd26, 5'd24, 5'd25,
		5'd19, 5'd21, 5'd26, 5'd27, 5'd27, 5'd26, 5'd27, 5'd24,
		5'd21, 5'd21, 5'd26, 5'd26, 5'd28, 5'd27, 5'd27, 5'd27,
		5'd20, 5'd24, 5'd20, 5'd21, 5'd22, 5'd21, 5'd21, 5'd23,
		5'd22, 5'd22, 5'd25, 5'd25, 5'd24, 5'd24, 5'd26, 5'd23,
		5'd26, 5'd27, 5'd26, 5'd26, 5'd27, 5'd27, 5'd27, 5'd27,
		5'd27, 5'd28, 5'd27, 5'd27, 5'd27, 5'd27, 5'd27, 5'd26,
		5'd30
	};

	// Number of codes of each length
	function automatic idx_arr_t calc_count();
		idx_arr_t r;
		for (int l = 0; l <= MaxLen; l++) r[l] = '0;
		for (int s = 0; s < SymCount; s++) r[CODE_LEN[s]] = r[CODE_LEN[s]] + 9'd1;
		return r;
	endfunction

	localparam idx_arr_t LEN_COUNT = calc_count();

	// First canonical code value of each length
	function automatic code_arr_t calc_first();
		code_arr_t r;
		logic [31:0] nxt;
		nxt = '0;
		r[0] = '0;
		for (int l = 1; l <= MaxLen; l++) begin
			r[l] = nxt[29:0];
			nxt = (nxt + {23'd0, LEN_COUNT[l]}) << 1;
		end
		return r;
	endfunction

	localparam code_arr_t FIRST_CODE = calc_first();

	// Index of the first symbol of each length in the sorted table
	function automatic idx_arr_t calc_base();
		idx_arr_t r;
		logic [8:0] acc;
		acc = '0;
		for (int l = 0; l <= MaxLen; l++) begin
			r[l] = acc;
			acc = acc + LEN_COUNT[l];
		end
		return r;
	endfunction

	localparam idx_arr_t LEN_BASE = calc_base();

	// Symbols sorted by code length, then by value
	function automatic sym_arr_t calc_syms();
		sym_arr_t r;
		int k;
		k = 0;
		for (int s = 0; s < SymCount; s++) r[s] = '0;
		for (int l = 1; l <= MaxLen; l++) begin
			for (int s = 0; s < SymCount; s++) begin
				if (int'(CODE_LEN[s]) == l) begin
					r[k] = 9'(s);
					k++;
				end
			end
		end
		return r;
	endfunction

	localparam sym_arr_t SORTED_SYM = calc_syms();

endpackage

>>> rtl/core/hpack_huffman_decoder.sv
`timescale 1ns / 1ps
// HPACK Huffman string decoder.
// Input channel (in_valid/in_ready): one coded byte per beat, bit 7 first,
// with last_byte marking the final byte of a string.
// Output channel (out_valid/out_ready): one result beat per input beat with
// up to two decoded octets, an EOS flag, an error flag and string_done.
// Each byte is loaded, walks the canonical code one bit per cycle through
// its eight bits, then is handed off to the output register. A byte arriving
// after EOS or an error finishes its walk early, without decoding any bit.
// The per-bit step (code compare and sorted-symbol lookup) sets the rate.
// A finished result sits in an output register, so the next byte is taken
// while the receiver stalls; a second result waits until that one is taken.
// After EOS or an error, bytes are ignored until a byte marked last, which
// also drops any trailing partial code and returns the walk to the root.
// Reset returns the walk to the root, clears the halt and empties the output.
module hpack_huffman_decoder import hpack_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] first_symbol,
	output logic       first_valid,
	output logic [7:0] second_symbol,
	output logic       second_valid,
	output logic       end_symbol_seen,
	output logic       code_error,
	output logic       string_done
);

	hpack_cmd_t  cmd;
	hpack_stat_t stat;

	hpack_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	hpack_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.data_byte       (data_byte),
		.last_byte       (last_byte),
		.first_symbol    (first_symbol),
		.first_valid     (first_valid),
		.second_symbol   (second_symbol),
		.second_valid    (second_valid),
		.end_symbol_seen (end_symbol_seen),
		.code_error      (code_error),
		.string_done     (string_done)
	);

`ifndef SYNTHESIS
	a_second_needs_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!second_valid || first_valid))
		else $error("second symbol without first");

	a_eos_err_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(end_symbol_seen && code_error))
		else $error("EOS and error in one beat");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("accepted a beat while decoding");
`endif

endmodule

>>> rtl/core/hpack_ctrl.sv
`timescale 1ns / 1ps

module hpack_ctrl import hpack_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  hpack_stat_t stat,
	output hpack_cmd_t  cmd
);

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

	state_t     state_q;
	logic [2:0] bit_cnt_q;
	logic       slot_free;

	assign slot_free  = !out_valid || out_ready;
	assign in_ready   = (state_q == ST_IDLE);
	assign cmd.load   = in_valid && in_ready;
	assign cmd.step   = (state_q == ST_RUN);
	assign cmd.finish = (state_q == ST_DONE) && slot_free;

	// Sequencer: one code bit per cycle, then hand the beat to the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bit_cnt_q <= '0;
			out_valid <= 1'b0;
		end else begin
			// taken beat drops valid unless a new one is handed off this cycle
			if (out_valid && out_ready && !cmd.finish) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q   <= ST_RUN;
						bit_cnt_q <= '0;
					end
				end
				ST_RUN: begin
					bit_cnt_q <= bit_cnt_q + 3'd1;
					if (stat.halted || bit_cnt_q == 3'd7) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (slot_free) begin
						out_valid <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/core/hpack_dp.sv
`timescale 1ns / 1ps

module hpack_dp import hpack_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  hpack_cmd_t  cmd,
	output hpack_stat_t stat,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic [7:0]  first_symbol,
	output logic        first_valid,
	output logic [7:0]  second_symbol,
	output logic        second_valid,
	output logic        end_symbol_seen,
	output logic        code_error,
	output logic        string_done
);

	// Walk state: partial code and its length stand for the tree node
	logic [29:0] code_q;
	logic [4:0]  len_q;
	logic        halted_q;
	// Per-beat working registers
	logic [7:0]  byte_q;
	logic        last_q;
	logic [7:0]  sym0_q, sym1_q;
	logic [1:0]  cnt_q;
	logic        eos_q, err_q;

	logic [29:0] new_code, offset;
	logic [4:0]  new_len;
	logic        hit;
	logic [8:0]  sym_idx, sym;

	// Canonical decode of one more bit
	always_comb begin
		new_code = {code_q[28:0], byte_q[7]};
		new_len  = len_q + 5'd1;
		offset   = new_code - FIRST_CODE[new_len];
		hit      = offset < {21'd0, LEN_COUNT[new_len]};
		sym_idx  = LEN_BASE[new_len] + offset[8:0];
		sym      = SORTED_SYM[sym_idx];
	end

	assign stat.halted = halted_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q   <= '0;
			len_q    <= '0;
			halted_q <= 1'b0;
		end else if (cmd.step && !halted_q) begin
			if (hit) begin
				code_q <= '0;
				len_q  <= '0;
				if (sym == EOS_SYM) halted_q <= 1'b1;
			end else if (int'(new_len) == MaxLen) begin
				halted_q <= 1'b1;
			end else begin
				code_q <= new_code;
				len_q  <= new_len;
			end
		end else if (cmd.finish && last_q) begin
			code_q   <= '0;
			len_q    <= '0;
			halted_q <= 1'b0;
		end
	end

	// Beat capture and symbol collection
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q <= data_byte;
			last_q <= last_byte;
			sym0_q <= '0;
			sym1_q <= '0;
			cnt_q  <= '0;
			eos_q  <= 1'b0;
			err_q  <= 1'b0;
		end else if (cmd.step && !halted_q) begin
			byte_q <= {byte_q[6:0], 1'b0};
			if (hit) begin
				if (sym == EOS_SYM) begin
					eos_q <= 1'b1;
				end else if (cnt_q == 2'd0) begin
					sym0_q <= sym[7:0];
					cnt_q  <= 2'd1;
				end else if (cnt_q == 2'd1) begin
					sym1_q <= sym[7:0];
					cnt_q  <= 2'd2;
				end
			end else if (int'(new_len) == MaxLen) begin
				err_q <= 1'b1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			first_symbol    <= sym0_q;
			first_valid     <= (cnt_q != 2'd0);
			second_symbol   <= sym1_q;
			second_valid    <= (cnt_q == 2'd2);
			end_symbol_seen <= eos_q;
			code_error      <= err_q;
			string_done     <= last_q;
		end
	end

endmodule
